// ===== rtl/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types, constants and helpers for the sphere tracing pixel block.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int VAL_W             = 25;   // signed fixed-point value width
  localparam int RAD_W             = 2 * VAL_W;  // sum of three squares
  localparam int ROOT_W            = RAD_W / 2;
  localparam int DEF_COLUMNS       = 40;
  localparam int DEF_ROWS          = 20;
  localparam int DEF_FRACTION_BITS = 16;

  localparam logic signed [63:0] VAL_MAX = 64'sd16777215;
  localparam logic signed [63:0] VAL_MIN = -64'sd16777216;

  localparam logic [6:0] GLYPH_HIT  = 7'd35;  // '#'
  localparam logic [6:0] GLYPH_MISS = 7'd46;  // '.'

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic [5:0] column;
    logic [4:0] row;
  } in_t;

  typedef struct packed {
    logic [6:0] glyph;
    logic       hit;
    logic       escaped;
    logic [7:0] steps_used;
    logic [9:0] frame_address;
  } out_t;

  typedef struct packed {
    logic [23:0] sphere_radius;
    val_t        camera_depth;
    val_t        target_depth;
    logic [23:0] vertical_scale;
    logic [23:0] escape_bound;
    logic [7:0]  max_steps;
    logic [15:0] hit_threshold;
  } cfg_t;

  typedef enum logic [2:0] {
    CFG_SPHERE_RADIUS  = 3'd0,
    CFG_CAMERA_DEPTH   = 3'd1,
    CFG_TARGET_DEPTH   = 3'd2,
    CFG_VERTICAL_SCALE = 3'd3,
    CFG_ESCAPE_BOUND   = 3'd4,
    CFG_MAX_STEPS      = 3'd5,
    CFG_HIT_THRESHOLD  = 3'd6
  } cfg_index_t;

  localparam logic [23:0] RST_SPHERE_RADIUS  = 24'd13107;
  localparam val_t        RST_CAMERA_DEPTH   = -25'sd196608;
  localparam val_t        RST_TARGET_DEPTH   = -25'sd98304;
  localparam logic [23:0] RST_VERTICAL_SCALE = 24'd49152;
  localparam logic [23:0] RST_ESCAPE_BOUND   = 24'd6488064;
  localparam logic [7:0]  RST_MAX_STEPS      = 8'd150;
  localparam logic [15:0] RST_HIT_THRESHOLD  = 16'd8;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE,
    OP_DIV_TX, OP_SET_TX, OP_DIV_TY, OP_SET_TY, OP_MUL_TY, OP_SCALE_TY,
    OP_SQ0, OP_SQ1, OP_SQ2, OP_SQ3, OP_SQRT,
    OP_LEN, OP_ZERO_DIR,
    OP_DIV_DX, OP_SET_DX, OP_DIV_DY, OP_SET_DY, OP_DIV_DZ, OP_SET_DZ,
    OP_INIT, OP_ESC, OP_HIT, OP_DIST,
    OP_MUL_UX, OP_UPD_X, OP_UPD_Y, OP_UPD_Z,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   pos;   // squares of the position rather than the direction
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
    logic root_zero;
    logic steps_done;
    logic escape;
    logic hit_now;
  } dp_status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TX_DIV, ST_TX_WAIT, ST_TY_DIV, ST_TY_WAIT, ST_TY_MUL, ST_TY_SCALE,
    ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_SQRT, ST_SQRT_WAIT,
    ST_LEN,
    ST_DX_DIV, ST_DX_WAIT, ST_DY_DIV, ST_DY_WAIT, ST_DZ_DIV, ST_DZ_WAIT,
    ST_INIT, ST_CHECK, ST_DIST,
    ST_UPD0, ST_UPD1, ST_UPD2, ST_UPD3,
    ST_FIN
  } state_t;

  // saturate to the signed value range
  function automatic val_t sat(input logic signed [63:0] v);
    if (v > VAL_MAX) begin
      return val_t'(VAL_MAX);
    end else if (v < VAL_MIN) begin
      return val_t'(VAL_MIN);
    end
    return val_t'(v);
  endfunction

  // magnitude; the most negative value maps to 2^24 correctly as unsigned
  function automatic logic [VAL_W-1:0] mag(input val_t v);
    if (v[VAL_W-1]) begin
      return VAL_W'(-v);
    end
    return VAL_W'(v);
  endfunction

endpackage

// ===== rtl/stp_div.sv =====
// ----------------------------------------------------------------------------
// stp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stp_div #(
  parameter int DVD_W = 41,
  parameter int DVS_W = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   rem_sh;
  logic             q_bit;
  logic [DVS_W:0]   rem_next;

  assign rem_sh   = {rem, dvd[DVD_W-1]};
  assign q_bit    = rem_sh >= {1'b0, dvs};
  assign rem_next = q_bit ? rem_sh - {1'b0, dvs} : rem_sh;
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], q_bit};
      rem <= rem_next[DVS_W-1:0];
    end
  end

endmodule

// ===== rtl/stp_sqrt.sv =====
// ----------------------------------------------------------------------------
// stp_sqrt
// Digit-recurrence integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module stp_sqrt #(
  parameter int RAD_W = 50
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [RAD_W-1:0]     radicand,
  output logic                 busy,
  output logic [RAD_W/2-1:0]   root
);
  localparam int ROOT_W = RAD_W / 2;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W:0]   rem;
  logic [CNT_W-1:0]  cnt;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic              take;
  logic [ROOT_W+2:0] rem_next;

  assign rem_sh   = {rem, rad[RAD_W-1:RAD_W-2]};
  assign trial    = {1'b0, root, 2'b01};
  assign take     = rem_sh >= trial;
  assign rem_next = take ? rem_sh - trial : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(ROOT_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= rem_next[ROOT_W:0];
      root <= {root[ROOT_W-2:0], take};
    end
  end

endmodule

// ===== rtl/stp_datapath.sv =====
// ----------------------------------------------------------------------------
// stp_datapath
// Ray setup and march registers, shared multiplier, divider and square root.
// ----------------------------------------------------------------------------
module stp_datapath #(
  parameter int COLUMNS       = stp_pkg::DEF_COLUMNS,
  parameter int ROWS          = stp_pkg::DEF_ROWS,
  parameter int FRACTION_BITS = stp_pkg::DEF_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  stp_pkg::cfg_t      cfg,
  input  stp_pkg::in_t       pixel,
  input  stp_pkg::dp_cmd_t   cmd,
  output stp_pkg::dp_status_t status,
  output stp_pkg::out_t      result
);
  import stp_pkg::*;

  localparam int DVD_W = VAL_W + FRACTION_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRACTION_BITS - 1);

  val_t dx, dy, dz, px, py, pz, step_len;
  logic [ROOT_W-1:0] len;
  logic [RAD_W-1:0]  acc;
  logic [7:0]        steps;
  logic [5:0]        col;
  logic [4:0]        row;
  logic [9:0]        faddr;
  logic              hit_f, esc_f, div_neg;

  val_t mul_a, mul_b, sq_x, sq_y, sq_z, dist_calc;
  logic signed [RAD_W-1:0] prod;
  logic signed [63:0]      prod_w, prod_sh, qs;
  logic [15:0]             faddr_full;

  logic              div_start, sqrt_start, div_busy, sqrt_busy;
  logic [DVD_W-1:0]  dividend, quotient;
  logic [VAL_W-1:0]  divisor;
  logic [ROOT_W-1:0] root;

  stp_div #(.DVD_W(DVD_W), .DVS_W(VAL_W)) u_div (
    .clk, .rst, .start(div_start), .dividend, .divisor,
    .busy(div_busy), .quotient
  );

  stp_sqrt #(.RAD_W(RAD_W)) u_sqrt (
    .clk, .rst, .start(sqrt_start), .radicand(acc),
    .busy(sqrt_busy), .root
  );

  assign sq_x = cmd.pos ? px : dx;
  assign sq_y = cmd.pos ? py : dy;
  assign sq_z = cmd.pos ? pz : dz;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_TY: begin
        mul_a = dy;
        mul_b = $signed({1'b0, cfg.vertical_scale});
      end
      OP_SQ0:    begin mul_a = sq_x; mul_b = sq_x; end
      OP_SQ1:    begin mul_a = sq_y; mul_b = sq_y; end
      OP_SQ2:    begin mul_a = sq_z; mul_b = sq_z; end
      OP_MUL_UX: begin mul_a = dx; mul_b = step_len; end
      OP_UPD_X:  begin mul_a = dy; mul_b = step_len; end
      OP_UPD_Y:  begin mul_a = dz; mul_b = step_len; end
      default:   ;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    dividend  = '0;
    divisor   = len;
    case (cmd.op)
      OP_DIV_TX: begin
        div_start = 1'b1;
        dividend  = DVD_W'(col) << FRACTION_BITS;
        divisor   = VAL_W'(COLUMNS);
      end
      OP_DIV_TY: begin
        div_start = 1'b1;
        dividend  = DVD_W'(row) << FRACTION_BITS;
        divisor   = VAL_W'(ROWS);
      end
      OP_DIV_DX: begin
        div_start = 1'b1;
        dividend  = DVD_W'(mag(dx)) << FRACTION_BITS;
      end
      OP_DIV_DY: begin
        div_start = 1'b1;
        dividend  = DVD_W'(mag(dy)) << FRACTION_BITS;
      end
      OP_DIV_DZ: begin
        div_start = 1'b1;
        dividend  = DVD_W'(mag(dz)) << FRACTION_BITS;
      end
      default: ;
    endcase
  end

  assign sqrt_start = (cmd.op == OP_SQRT);

  assign prod_w     = 64'(prod);
  assign prod_sh    = prod_w >>> FRACTION_BITS;
  assign qs         = div_neg ? -$signed(64'(quotient)) : $signed(64'(quotient));
  assign dist_calc  = sat($signed(64'(root)) - $signed(64'(cfg.sphere_radius)));
  assign faddr_full = 16'(pixel.row) * 16'(COLUMNS) + 16'(pixel.column);

  assign status.div_busy   = div_busy;
  assign status.sqrt_busy  = sqrt_busy;
  assign status.root_zero  = (root == '0);
  assign status.steps_done = (steps == cfg.max_steps);
  assign status.escape     = (mag(px) > {1'b0, cfg.escape_bound})
                          || (mag(py) > {1'b0, cfg.escape_bound})
                          || (mag(pz) > {1'b0, cfg.escape_bound});
  assign status.hit_now    = dist_calc < $signed(VAL_W'(cfg.hit_threshold));

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      OP_CAPTURE: begin
        col   <= pixel.column;
        row   <= pixel.row;
        faddr <= faddr_full[9:0];
        hit_f <= 1'b0;
        esc_f <= 1'b0;
      end
      OP_DIV_TX, OP_DIV_TY: div_neg <= 1'b0;
      OP_DIV_DX:   div_neg <= dx[VAL_W-1];
      OP_DIV_DY:   div_neg <= dy[VAL_W-1];
      OP_DIV_DZ:   div_neg <= dz[VAL_W-1];
      OP_SET_TX:   dx <= sat(qs - HALF);
      OP_SET_TY:   dy <= sat(qs - HALF);
      OP_SCALE_TY: begin
        dy <= sat(prod_sh);
        dz <= sat(64'(cfg.target_depth) - 64'(cfg.camera_depth));
      end
      OP_SQ1:      acc <= RAD_W'($unsigned(prod));
      OP_SQ2, OP_SQ3: acc <= acc + RAD_W'($unsigned(prod));
      OP_LEN:      len <= root;
      OP_ZERO_DIR: begin
        dx <= '0;
        dy <= '0;
        dz <= '0;
      end
      OP_SET_DX:   dx <= sat(qs);
      OP_SET_DY:   dy <= sat(qs);
      OP_SET_DZ:   dz <= sat(qs);
      OP_INIT: begin
        px    <= '0;
        py    <= '0;
        pz    <= cfg.camera_depth;
        steps <= '0;
      end
      OP_ESC:      esc_f <= 1'b1;
      OP_HIT:      hit_f <= 1'b1;
      OP_DIST:     step_len <= dist_calc;
      OP_UPD_X:    px <= sat(64'(px) + prod_sh);
      OP_UPD_Y:    py <= sat(64'(py) + prod_sh);
      OP_UPD_Z: begin
        pz    <= sat(64'(pz) + prod_sh);
        steps <= steps + 1'b1;
      end
      OP_FINISH: begin
        result.glyph         <= hit_f ? GLYPH_HIT : GLYPH_MISS;
        result.hit           <= hit_f;
        result.escaped       <= esc_f;
        result.steps_used    <= steps;
        result.frame_address <= faddr;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/stp_ctrl.sv =====
// ----------------------------------------------------------------------------
// stp_ctrl
// Sequencer for ray setup, the march loop and the result handshake.
// ----------------------------------------------------------------------------
module stp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_ready,
  output logic                result_valid,
  input  logic                result_ready,
  input  stp_pkg::dp_status_t status,
  output stp_pkg::dp_cmd_t    cmd
);
  import stp_pkg::*;

  state_t state, state_next;
  logic   marching, marching_next;
  logic   result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      marching     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      marching     <= marching_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next        = state;
    marching_next     = marching;
    result_valid_next = result_valid && !result_ready;
    cmd.op            = OP_NONE;
    cmd.pos           = marching;
    pixel_ready       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        pixel_ready = 1'b1;
        if (pixel_valid) begin
          cmd.op        = OP_CAPTURE;
          marching_next = 1'b0;
          state_next    = ST_TX_DIV;
        end
      end
      ST_TX_DIV: begin
        cmd.op     = OP_DIV_TX;
        state_next = ST_TX_WAIT;
      end
      ST_TX_WAIT: if (!status.div_busy) begin
        cmd.op     = OP_SET_TX;
        state_next = ST_TY_DIV;
      end
      ST_TY_DIV: begin
        cmd.op     = OP_DIV_TY;
        state_next = ST_TY_WAIT;
      end
      ST_TY_WAIT: if (!status.div_busy) begin
        cmd.op     = OP_SET_TY;
        state_next = ST_TY_MUL;
      end
      ST_TY_MUL: begin
        cmd.op     = OP_MUL_TY;
        state_next = ST_TY_SCALE;
      end
      ST_TY_SCALE: begin
        cmd.op     = OP_SCALE_TY;
        state_next = ST_SQ0;
      end
      ST_SQ0: begin
        cmd.op     = OP_SQ0;
        state_next = ST_SQ1;
      end
      ST_SQ1: begin
        cmd.op     = OP_SQ1;
        state_next = ST_SQ2;
      end
      ST_SQ2: begin
        cmd.op     = OP_SQ2;
        state_next = ST_SQ3;
      end
      ST_SQ3: begin
        cmd.op     = OP_SQ3;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op     = OP_SQRT;
        state_next = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: if (!status.sqrt_busy) begin
        state_next = marching ? ST_DIST : ST_LEN;
      end
      ST_LEN: begin
        if (status.root_zero) begin
          cmd.op     = OP_ZERO_DIR;
          state_next = ST_INIT;
        end else begin
          cmd.op     = OP_LEN;
          state_next = ST_DX_DIV;
        end
      end
      ST_DX_DIV: begin
        cmd.op     = OP_DIV_DX;
        state_next = ST_DX_WAIT;
      end
      ST_DX_WAIT: if (!status.div_busy) begin
        cmd.op     = OP_SET_DX;
        state_next = ST_DY_DIV;
      end
      ST_DY_DIV: begin
        cmd.op     = OP_DIV_DY;
        state_next = ST_DY_WAIT;
      end
      ST_DY_WAIT: if (!status.div_busy) begin
        cmd.op     = OP_SET_DY;
        state_next = ST_DZ_DIV;
      end
      ST_DZ_DIV: begin
        cmd.op     = OP_DIV_DZ;
        state_next = ST_DZ_WAIT;
      end
      ST_DZ_WAIT: if (!status.div_busy) begin
        cmd.op     = OP_SET_DZ;
        state_next = ST_INIT;
      end
      ST_INIT: begin
        cmd.op        = OP_INIT;
        marching_next = 1'b1;
        state_next    = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.steps_done) begin
          state_next = ST_FIN;
        end else if (status.escape) begin
          cmd.op     = OP_ESC;
          state_next = ST_FIN;
        end else begin
          state_next = ST_SQ0;
        end
      end
      ST_DIST: begin
        if (status.hit_now) begin
          cmd.op     = OP_HIT;
          state_next = ST_FIN;
        end else begin
          cmd.op     = OP_DIST;
          state_next = ST_UPD0;
        end
      end
      ST_UPD0: begin
        cmd.op     = OP_MUL_UX;
        state_next = ST_UPD1;
      end
      ST_UPD1: begin
        cmd.op     = OP_UPD_X;
        state_next = ST_UPD2;
      end
      ST_UPD2: begin
        cmd.op     = OP_UPD_Y;
        state_next = ST_UPD3;
      end
      ST_UPD3: begin
        cmd.op     = OP_UPD_Z;
        state_next = ST_CHECK;
      end
      ST_FIN: if (!result_valid || result_ready) begin
        cmd.op            = OP_FINISH;
        result_valid_next = 1'b1;
        state_next        = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_idle_units_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !status.div_busy && !status.sqrt_busy)
    else $error("arithmetic unit busy while idle");

  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV_TX || cmd.op == OP_DIV_TY || cmd.op == OP_DIV_DX
     || cmd.op == OP_DIV_DY || cmd.op == OP_DIV_DZ) |-> !status.div_busy)
    else $error("divide started while divider busy");

  a_sqrt_start_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_SQRT |-> !status.sqrt_busy)
    else $error("square root started while unit busy");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_FINISH |=> result_valid)
    else $error("finished transaction not presented");

endmodule

// ===== rtl/sphere_tracing_pixel_top.sv =====
// ----------------------------------------------------------------------------
// sphere_tracing_pixel_top
// Sphere-tracing ray marcher for one pixel: glyph and framebuffer address.
// ----------------------------------------------------------------------------
// One pixel (column, row) is taken per transaction and one result comes back.
// Work is sequential, one pixel at a time: the ray is set up with up to five passes
// of a shared one-bit-per-cycle divider and one square root, then each march
// step squares the position on the shared multiplier and runs the square-root
// unit, the square root in the march loop being the dominant cost. A finished
// result sits in the output register while the next pixel is accepted.
// Configuration writes take effect immediately and should be made while the
// block is idle.
// ----------------------------------------------------------------------------
module sphere_tracing_pixel_top #(
  parameter int COLUMNS       = stp_pkg::DEF_COLUMNS,
  parameter int ROWS          = stp_pkg::DEF_ROWS,
  parameter int FRACTION_BITS = stp_pkg::DEF_FRACTION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  // pixel transaction
  input  logic                     pixel_valid,
  output logic                     pixel_ready,
  input  stp_pkg::in_t             pixel,
  // result transaction
  output logic                     result_valid,
  input  logic                     result_ready,
  output stp_pkg::out_t            result,
  // configuration writes
  input  logic                     cfg_write,
  input  logic [2:0]               cfg_index,
  input  logic [stp_pkg::VAL_W-1:0] cfg_data
);
  import stp_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sphere_radius  <= RST_SPHERE_RADIUS;
      cfg.camera_depth   <= RST_CAMERA_DEPTH;
      cfg.target_depth   <= RST_TARGET_DEPTH;
      cfg.vertical_scale <= RST_VERTICAL_SCALE;
      cfg.escape_bound   <= RST_ESCAPE_BOUND;
      cfg.max_steps      <= RST_MAX_STEPS;
      cfg.hit_threshold  <= RST_HIT_THRESHOLD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SPHERE_RADIUS:  cfg.sphere_radius  <= cfg_data[23:0];
        CFG_CAMERA_DEPTH:   cfg.camera_depth   <= $signed(cfg_data);
        CFG_TARGET_DEPTH:   cfg.target_depth   <= $signed(cfg_data);
        CFG_VERTICAL_SCALE: cfg.vertical_scale <= cfg_data[23:0];
        CFG_ESCAPE_BOUND:   cfg.escape_bound   <= cfg_data[23:0];
        CFG_MAX_STEPS:      cfg.max_steps      <= cfg_data[7:0];
        CFG_HIT_THRESHOLD:  cfg.hit_threshold  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer: setup, march loop, result handoff
  stp_ctrl u_ctrl (
    .clk, .rst,
    .pixel_valid, .pixel_ready,
    .result_valid, .result_ready,
    .status, .cmd
  );

  // arithmetic and the output register
  stp_datapath #(
    .COLUMNS(COLUMNS), .ROWS(ROWS), .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk, .rst, .cfg, .pixel, .cmd, .status, .result
  );

endmodule

// ===== tb/stp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_checker
// Watches the pixel, result and configuration ports of the sphere tracer,
// predicts each pixel's result and compares it with what comes out.
// ----------------------------------------------------------------------------
module stp_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pixel_valid,
  input  logic                      pixel_ready,
  input  stp_pkg::in_t              pixel,
  input  logic                      result_valid,
  input  logic                      result_ready,
  input  stp_pkg::out_t             result,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [stp_pkg::VAL_W-1:0] cfg_data,
  output int                        errors,
  output int                        pending
);
  import stp_pkg::*;

  localparam int COLS = DEF_COLUMNS;
  localparam int RWS  = DEF_ROWS;
  localparam int FB   = DEF_FRACTION_BITS;

  longint unsigned radius, vscale, bound_r, steps_max, thresh;
  longint          cam_z, tgt_z;
  out_t            expected_q[$];

  function automatic longint clamp25(longint v);
    if (v > 64'sd16777215) return 64'sd16777215;
    if (v < -64'sd16777216) return -64'sd16777216;
    return v;
  endfunction

  function automatic longint root_of(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint norm3(longint x, longint y, longint z);
    return root_of(longint'(x * x + y * y + z * z));
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic out_t trace_pixel(in_t px);
    out_t   o;
    longint one, half, tx, ty, dx, dy, dz, len, x, y, z, sdist, bnd;
    longint unsigned col, rw, i, steps;
    logic   hit, esc;
    one   = 64'sd1 << FB;
    half  = 64'sd1 << (FB - 1);
    col   = px.column;
    rw    = px.row;
    hit   = 1'b0;
    esc   = 1'b0;
    steps = 0;
    tx = clamp25(longint'(col * 65536 / COLS) - half);
    ty = clamp25(longint'(rw * 65536 / RWS) - half);
    ty = clamp25((ty * longint'(vscale)) >>> FB);
    dx = tx;
    dy = ty;
    dz = clamp25(tgt_z - cam_z);
    len = norm3(dx, dy, dz);
    if (len == 0) begin
      dx = 0; dy = 0; dz = 0;
    end else begin
      dx = clamp25((dx * one) / len);
      dy = clamp25((dy * one) / len);
      dz = clamp25((dz * one) / len);
    end
    x = 0; y = 0; z = cam_z;
    bnd = longint'(bound_r);
    for (i = 0; i < steps_max; i++) begin
      steps = i;
      // escape test comes first in every step
      if (absl(x) > bnd || absl(y) > bnd || absl(z) > bnd) begin
        esc = 1'b1;
        break;
      end
      sdist = clamp25(norm3(x, y, z) - longint'(radius));
      if (sdist < longint'(thresh)) begin
        hit = 1'b1;
        break;
      end
      x = clamp25(x + ((dx * sdist) >>> FB));
      y = clamp25(y + ((dy * sdist) >>> FB));
      z = clamp25(z + ((dz * sdist) >>> FB));
    end
    if (!hit && !esc) steps = steps_max;
    o.glyph         = hit ? GLYPH_HIT : GLYPH_MISS;
    o.hit           = hit;
    o.escaped       = esc;
    o.steps_used    = steps[7:0];
    o.frame_address = 10'(rw * COLS + col);
    return o;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_t e;
    if (rst) begin
      radius    <= RST_SPHERE_RADIUS;
      cam_z     <= RST_CAMERA_DEPTH;
      tgt_z     <= RST_TARGET_DEPTH;
      vscale    <= RST_VERTICAL_SCALE;
      bound_r   <= RST_ESCAPE_BOUND;
      steps_max <= RST_MAX_STEPS;
      thresh    <= RST_HIT_THRESHOLD;
      errors = 0;
      expected_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index_t'(cfg_index))
          CFG_SPHERE_RADIUS:  radius    <= cfg_data[23:0];
          CFG_CAMERA_DEPTH:   cam_z     <= longint'($signed(cfg_data));
          CFG_TARGET_DEPTH:   tgt_z     <= longint'($signed(cfg_data));
          CFG_VERTICAL_SCALE: vscale    <= cfg_data[23:0];
          CFG_ESCAPE_BOUND:   bound_r   <= cfg_data[23:0];
          CFG_MAX_STEPS:      steps_max <= cfg_data[7:0];
          CFG_HIT_THRESHOLD:  thresh    <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (pixel_valid && pixel_ready) expected_q.push_back(trace_pixel(pixel));
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $time, result);
        end else begin
          e = expected_q.pop_front();
          if (result !== e) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, e, result);
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Pixel stimulus and verdict for the sphere tracer; the checker does the rest.
// ----------------------------------------------------------------------------
// Directed pixels (frame corners, center, out-of-frame indexes) run under the
// reset settings and under special settings: zero-length ray, zero step
// limit, zero hit threshold, a camera outside the escape bound, and register
// extremes. Five phases of random pixels follow, all but the last under random settings.
// ----------------------------------------------------------------------------
module tb;
  import stp_pkg::*;

  localparam longint CYCLE_LIMIT = 64'd6000000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             pixel_valid = 1'b0;
  logic             pixel_ready;
  in_t              pixel = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  out_t             result;
  logic             cfg_write = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [VAL_W-1:0] cfg_data = '0;
  int               errors, pending;
  longint           cycles = 0;
  logic             ready_burst = 1'b0;  // no receiver stalls while set

  always #5 clk = ~clk;

  sphere_tracing_pixel_top DUT (
    .clk, .rst, .pixel_valid, .pixel_ready, .pixel,
    .result_valid, .result_ready, .result,
    .cfg_write, .cfg_index, .cfg_data
  );

  stp_checker u_checker (
    .clk, .rst, .pixel_valid, .pixel_ready, .pixel,
    .result_valid, .result_ready, .result,
    .cfg_write, .cfg_index, .cfg_data, .errors, .pending
  );

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stall before each result, ready never dropped and
  // raised in the same step
  initial begin
    int w;
    @(negedge rst);
    forever begin
      w = ready_burst ? 0 : $urandom_range(0, 13);
      if (w > 0) begin
        result_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!(result_valid && result_ready)) @(posedge clk);
    end
  end

  // one pixel transaction; gap 0 keeps valid high into the next item
  task automatic send_pixel(input logic [5:0] col, input logic [4:0] rw, input logic burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid  <= 1'b1;
    pixel.column <= col;
    pixel.row    <= rw;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
  endtask

  // drain all results and let the block settle before touching registers
  task automatic settle();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // the enable drops for one cycle between writes
  task automatic write_reg(input cfg_index_t idx, input logic [VAL_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [23:0] rad, input logic [24:0] cam,
                           input logic [24:0] tgt, input logic [23:0] vs,
                           input logic [23:0] esc, input logic [7:0] ms,
                           input logic [15:0] th);
    write_reg(CFG_SPHERE_RADIUS, {1'b0, rad});
    write_reg(CFG_CAMERA_DEPTH, cam);
    write_reg(CFG_TARGET_DEPTH, tgt);
    write_reg(CFG_VERTICAL_SCALE, {1'b0, vs});
    write_reg(CFG_ESCAPE_BOUND, {1'b0, esc});
    write_reg(CFG_MAX_STEPS, {17'd0, ms});
    write_reg(CFG_HIT_THRESHOLD, {9'd0, th});
  endtask

  initial begin
    int   cam;
    logic burst;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: corners, center, out-of-frame indexes
    send_pixel(6'd0, 5'd0, 1'b0);
    send_pixel(6'd39, 5'd19, 1'b1);
    send_pixel(6'd20, 5'd10, 1'b1);
    send_pixel(6'd63, 5'd31, 1'b0);
    send_pixel(6'd42, 5'd21, 1'b0);
    send_pixel(6'd21, 5'd10, 1'b0);
    settle();

    // zero-length ray at the frame center, zero threshold
    write_all(24'd13107, -25'sd196608, -25'sd196608, 24'd49152, 24'd6488064, 8'd20, 16'd0);
    send_pixel(6'd20, 5'd10, 1'b0);
    send_pixel(6'd5, 5'd3, 1'b0);
    settle();
    // zero step limit
    write_reg(CFG_MAX_STEPS, 25'd0);
    send_pixel(6'd10, 5'd4, 1'b0);
    settle();
    // camera starts outside the escape bound
    write_all(24'd13107, -25'sd196608, -25'sd98304, 24'd49152, 24'd0, 8'd150, 16'd8);
    send_pixel(6'd20, 5'd10, 1'b0);
    settle();
    // register maxima / minima
    write_all(24'hFFFFFF, -25'sd16777216, 25'sd16777215, 24'hFFFFFF, 24'hFFFFFF,
              8'd255, 16'hFFFF);
    send_pixel(6'd0, 5'd31, 1'b0);
    send_pixel(6'd63, 5'd0, 1'b0);
    settle();
    write_all(24'd0, 25'sd16777215, -25'sd16777216, 24'd0, 24'hFFFFFF, 8'd1, 16'd1);
    send_pixel(6'd39, 5'd0, 1'b0);
    send_pixel(6'd21, 5'd31, 1'b0);
    settle();
    write_all(24'd65536, -25'sd196608, 25'sd0, 24'd65536, 24'd655360, 8'd255, 16'd65535);
    send_pixel(6'd20, 5'd10, 1'b0);
    send_pixel(6'd33, 5'd17, 1'b0);
    settle();

    // random phases
    for (int ph = 0; ph < 5; ph++) begin
      cam = -int'($urandom_range(32768, 400000));
      if (ph == 4) begin
        write_all(24'(RST_SPHERE_RADIUS), RST_CAMERA_DEPTH, RST_TARGET_DEPTH,
                  24'(RST_VERTICAL_SCALE), RST_ESCAPE_BOUND, RST_MAX_STEPS,
                  RST_HIT_THRESHOLD);
      end else begin
        write_all(24'($urandom_range(0, 150000)), 25'(cam),
                  25'(cam + int'($urandom_range(0, 300000))),
                  24'($urandom_range(0, 200000)),
                  ($urandom_range(0, 3) == 0) ? 24'($urandom) :
                                                24'($urandom_range(100000, 6488064)),
                  8'($urandom_range(1, 80)), 16'($urandom_range(0, 400)));
      end
      burst = ($urandom_range(0, 2) == 0);
      ready_burst <= burst;
      for (int k = 0; k < 30; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_pixel(6'($urandom), 5'($urandom), burst);
        end else begin
          send_pixel(6'($urandom_range(0, 39)), 5'($urandom_range(0, 19)), burst);
        end
      end
      settle();
      ready_burst <= 1'b0;
    end

    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
